// ===== hdl/lsbr_pkg.sv =====
// Shared types and constants for the line-scan beacon run finder.
// No dependencies; every other file refers to this package by scoped names.
package lsbr_pkg;

  localparam int PIXELS = 128;
  localparam int IDX_W  = $clog2(PIXELS);
  localparam int LEN_W  = $clog2(PIXELS + 1);
  localparam int CTR_W  = LEN_W + 1;

  localparam int THR_W  = 10;
  localparam int MINW_W = 8;
  localparam int CW_W   = 7;
  localparam int SMP_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTERED_WIDTH = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RST      = 10'd512;
  localparam logic [MINW_W-1:0] MIN_WIDTH_RST      = 8'd2;
  localparam logic [CW_W-1:0]   CENTERED_WIDTH_RST = 7'd8;

  localparam logic signed [7:0] NO_CENTER = -8'sd1;

  typedef enum logic [1:0] {
    DIR_NONE   = 2'd0,
    DIR_LEFT   = 2'd1,
    DIR_CENTER = 2'd2,
    DIR_RIGHT  = 2'd3
  } dir_e;

  typedef struct packed {
    dir_e               direction;
    logic signed [7:0]  center;
    logic [6:0]         best_start;
    logic [7:0]         best_width;
  } result_t;

endpackage

// ===== hdl/lsbr_ifs.sv =====
// Valid/ready channel interfaces for pixels in and results out.
// Depends on lsbr_pkg for field widths.
interface lsbr_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [lsbr_pkg::SMP_W-1:0]   sample;
  logic                         frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface lsbr_result_if;
  logic              valid;
  logic              ready;
  logic [1:0]        direction;
  logic signed [7:0] center;
  logic [6:0]        best_start;
  logic [7:0]        best_width;

  modport source (output valid, output direction, output center, output best_start,
                  output best_width, input ready);
  modport sink   (input valid, input direction, input center, input best_start,
                  input best_width, output ready);
endinterface

// ===== hdl/lsbr_tracker.sv =====
// Per-pixel run tracking, configuration registers and end-of-line classification.
// Depends on lsbr_pkg and lsbr_pixel_if.
module lsbr_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lsbr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lsbr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lsbr_pixel_if.sink                       pix_i,
  input  logic                             hold_i,
  output logic                             push_o,
  output lsbr_pkg::result_t                res_o
);

  logic [lsbr_pkg::THR_W-1:0]  threshold_q;
  logic [lsbr_pkg::MINW_W-1:0] min_width_q;
  logic [lsbr_pkg::CW_W-1:0]   centered_width_q;

  logic [lsbr_pkg::IDX_W-1:0] pix_idx_q, pix_idx_d;
  logic [lsbr_pkg::LEN_W-1:0] run_len_q, run_len_d;
  logic [lsbr_pkg::IDX_W-1:0] run_start_q, run_start_d;
  logic [lsbr_pkg::IDX_W-1:0] best_start_q, best_start_d;
  logic [lsbr_pkg::LEN_W-1:0] best_w_q, best_w_d;

  logic                       accept;
  logic                       lit;
  logic [lsbr_pkg::CTR_W-1:0] ctr_raw, ctr_c, win_hi, win_lo_sum;
  logic                       detect;

  assign pix_i.ready = ~hold_i;
  assign accept      = pix_i.valid & ~hold_i;
  assign lit         = pix_i.sample > threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q      <= lsbr_pkg::THRESHOLD_RST;
      min_width_q      <= lsbr_pkg::MIN_WIDTH_RST;
      centered_width_q <= lsbr_pkg::CENTERED_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsbr_pkg::CFG_THRESHOLD:      threshold_q      <= cfg_data_i[lsbr_pkg::THR_W-1:0];
        lsbr_pkg::CFG_MIN_WIDTH:      min_width_q      <= cfg_data_i[lsbr_pkg::MINW_W-1:0];
        lsbr_pkg::CFG_CENTERED_WIDTH: centered_width_q <= cfg_data_i[lsbr_pkg::CW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    best_start_d = best_start_q;
    best_w_d     = best_w_q;

    if (lit) begin
      if (run_len_q == '0) run_start_d = pix_idx_q;
      if (run_len_q < lsbr_pkg::LEN_W'(lsbr_pkg::PIXELS)) run_len_d = run_len_q + 1'b1;
      if (run_len_d > best_w_q) begin
        best_start_d = run_start_d;
        best_w_d     = run_len_d;
      end
    end else begin
      run_len_d = '0;
    end

    // hold the index at the last pixel on an overlong line
    if (pix_idx_q < lsbr_pkg::IDX_W'(lsbr_pkg::PIXELS - 1)) pix_idx_d = pix_idx_q + 1'b1;
    else                                                     pix_idx_d = pix_idx_q;

    // classify from the updated best run
    detect     = best_w_d > min_width_q;
    ctr_raw    = lsbr_pkg::CTR_W'(best_start_d) + lsbr_pkg::CTR_W'(best_w_d >> 1);
    ctr_c      = (ctr_raw > lsbr_pkg::CTR_W'(lsbr_pkg::PIXELS - 1)) ?
                 lsbr_pkg::CTR_W'(lsbr_pkg::PIXELS - 1) : ctr_raw;
    win_hi     = lsbr_pkg::CTR_W'(lsbr_pkg::PIXELS / 2) + lsbr_pkg::CTR_W'(centered_width_q);
    win_lo_sum = ctr_c + lsbr_pkg::CTR_W'(centered_width_q);

    res_o.best_start = best_start_d;
    res_o.best_width = best_w_d;
    if (!detect) begin
      res_o.direction = lsbr_pkg::DIR_NONE;
      res_o.center    = lsbr_pkg::NO_CENTER;
    end else begin
      res_o.center = {1'b0, ctr_c[lsbr_pkg::IDX_W-1:0]};
      priority if ((ctr_c < win_hi && win_lo_sum > lsbr_pkg::CTR_W'(lsbr_pkg::PIXELS / 2))
                   || ctr_c == lsbr_pkg::CTR_W'(lsbr_pkg::PIXELS / 2)) begin
        res_o.direction = lsbr_pkg::DIR_CENTER;
      end else if (ctr_c < lsbr_pkg::CTR_W'(lsbr_pkg::PIXELS / 2)) begin
        res_o.direction = lsbr_pkg::DIR_LEFT;
      end else begin
        res_o.direction = lsbr_pkg::DIR_RIGHT;
      end
    end
  end

  assign push_o = accept & pix_i.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_idx_q    <= '0;
      run_len_q    <= '0;
      run_start_q  <= '0;
      best_start_q <= '0;
      best_w_q     <= '0;
    end else if (accept) begin
      if (pix_i.frame_end) begin
        // start the next line from scratch
        pix_idx_q    <= '0;
        run_len_q    <= '0;
        run_start_q  <= '0;
        best_start_q <= '0;
        best_w_q     <= '0;
      end else begin
        pix_idx_q    <= pix_idx_d;
        run_len_q    <= run_len_d;
        run_start_q  <= run_start_d;
        best_start_q <= best_start_d;
        best_w_q     <= best_w_d;
      end
    end
  end

endmodule

// ===== hdl/lsbr_out_buf.sv =====
// Result register with one skid entry behind it.
// Depends on lsbr_pkg and lsbr_result_if.
module lsbr_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lsbr_pkg::result_t  data_i,
  output logic               full_o,
  lsbr_result_if.source      res_o
);

  logic              out_valid_q, skid_valid_q;
  lsbr_pkg::result_t out_q, skid_q;
  logic              pop;

  assign pop    = out_valid_q & res_o.ready;
  assign full_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // no push while the skid entry is occupied
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else                     out_valid_q  <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push_i) begin
      if (out_valid_q && !pop) skid_q <= data_i;
      else                     out_q  <= data_i;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.direction  = out_q.direction;
  assign res_o.center     = out_q.center;
  assign res_o.best_start = out_q.best_start;
  assign res_o.best_width = out_q.best_width;

endmodule

// ===== hdl/line_scan_beacon_run_finder_core.sv =====
// Top level of the line-scan beacon run finder.
// Depends on lsbr_pkg, lsbr_ifs, lsbr_tracker and lsbr_out_buf.
//
// Pixels enter on pix_i (valid/ready), one 10-bit sample per transfer, with
// frame_end set on the last pixel of a scan line. Each pixel updates the run
// tracker in the cycle it is taken; the frame_end pixel also produces one
// result, the longest lit run of the line and its classification, which is
// registered in the result register or skid entry. Other pixels give no result.
// Throughput is one pixel per cycle while the skid entry is free: the run update
// and classification are one compare/add path, tracker state to result register.
// Thresholds are written through cfg_we_i/cfg_idx_i/cfg_data_i, index 0
// threshold, 1 min_width, 2 centered_width; write them only while idle.
// Reset clears the line state and loads the register defaults (512, 2, 8);
// no result is pending after reset. When the receiver stalls, the result
// register holds and one more result fits in a skid entry; only when that
// entry is also full does pix_i.ready drop.
module line_scan_beacon_run_finder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lsbr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lsbr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lsbr_pixel_if.sink                       pix_i,
  lsbr_result_if.source                    res_o
);

  logic              push;
  logic              full;
  lsbr_pkg::result_t result;

  lsbr_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_i),
    .hold_i     (full),
    .push_o     (push),
    .res_o      (result)
  );

  lsbr_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (result),
    .full_o (full),
    .res_o  (res_o)
  );

endmodule

// ===== sim/tb_line_scan_beacon_run_finder_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for line_scan_beacon_run_finder_core: scan lines in, beacon results out.
// Depends on lsbr_pkg, lsbr_ifs and the core; predicts or looks up every result and compares it field by field.
module tb_line_scan_beacon_run_finder_core;

  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 4;
  localparam int PHASE_PIXELS   = 40;
  localparam int PHASE_LINES    = 1;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    int                thr;
    int                minw;
    int                cw;
    int                lead;
    int                run_a;
    int                gap;
    int                run_b;
    int                tail;
    int                dark;
    int                lit;
    bit                typed;
    lsbr_pkg::result_t want;
  } line_row_t;

  logic clk_i;
  logic rst_ni;
  logic                            cfg_we_i;
  logic [lsbr_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [lsbr_pkg::CFG_DATA_W-1:0] cfg_data_i;

  lsbr_pixel_if  pix_if ();
  lsbr_result_if res_if ();

  line_scan_beacon_run_finder_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  // Register copies and per-line tracker state of the predictor
  logic [lsbr_pkg::THR_W-1:0]  thr_q;
  logic [lsbr_pkg::MINW_W-1:0] minw_q;
  logic [lsbr_pkg::CW_W-1:0]   cw_q;
  logic [6:0]        pix_idx;
  logic [7:0]        run_len;
  logic [6:0]        run_st;
  logic [6:0]        best_st;
  logic [7:0]        best_w;

  lsbr_pkg::result_t          pending_beacons [$];
  logic [lsbr_pkg::SMP_W-1:0] line_buf [$];
  int                  n_fail;
  int                  items_sent;
  int                  quiet_cycles;
  bit                  src_calm;
  bit                  sink_calm;
  bit                  long_hold_req;
  bit                  short_lines;

  line_row_t line_table [20] = '{
    '{512, 2, 8,   0,   0, 0, 0, 1,   0, 1023, 1,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}},
    '{512, 2, 8,   0,   1, 0, 0, 0,   0, 1023, 1,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd1}},
    '{512, 2, 8,   1,   3, 0, 0, 0, 512,  513, 1,
      '{lsbr_pkg::DIR_LEFT, 8'sd2, 7'd1, 8'd3}},
    '{512, 2, 8,  60,   8, 0, 0, 4,   0, 1023, 1,
      '{lsbr_pkg::DIR_CENTER, 8'sd64, 7'd60, 8'd8}},
    '{512, 2, 8,   0,   3, 2, 3, 1, 100,  900, 0,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}},
    '{512, 2, 8,   2,   2, 1, 5, 0, 511, 1000, 0,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}},
    '{512, 2, 8,  70,   4, 0, 0, 0,   0, 1023, 1,
      '{lsbr_pkg::DIR_RIGHT, 8'sd72, 7'd70, 8'd4}},
    '{512, 2, 8,  54,   4, 0, 0, 1,   0, 1023, 1,
      '{lsbr_pkg::DIR_LEFT, 8'sd56, 7'd54, 8'd4}},
    '{512, 2, 8,  55,   4, 0, 0, 0,   0, 1023, 0,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}},
    '{512, 2, 8,   0, 128, 0, 0, 0,   0, 1023, 1,
      '{lsbr_pkg::DIR_CENTER, 8'sd64, 7'd0, 8'd128}},
    '{512, 2, 8, 100, 130, 0, 0, 0,   0, 1023, 1,
      '{lsbr_pkg::DIR_RIGHT, 8'sd127, 7'd100, 8'd128}},
    '{512, 2, 8, 150,   3, 0, 0, 0,   0, 1023, 0,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}},
    '{1023, 0, 0,  0,   4, 0, 0, 0,   0, 1023, 1,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}},
    '{0, 0, 0,    62,   4, 0, 0, 0,   0,    1, 1,
      '{lsbr_pkg::DIR_CENTER, 8'sd64, 7'd62, 8'd4}},
    '{0, 0, 0,    63,   4, 0, 0, 0,   0,    1, 0,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}},
    '{0, 0, 0,     0,   1, 0, 0, 0,   0,    1, 1,
      '{lsbr_pkg::DIR_LEFT, 8'sd0, 7'd0, 8'd1}},
    '{0, 128, 64,  0, 128, 0, 0, 0,   0, 1023, 1,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd128}},
    '{0, 0, 64,    0,   1, 0, 0, 0,   0,    5, 0,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}},
    '{0, 0, 64,  127,   1, 0, 0, 0,   0,    5, 0,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}},
    '{200, 127, 64, 0, 128, 0, 0, 0, 200,  201, 0,
      '{lsbr_pkg::DIR_NONE, lsbr_pkg::NO_CENTER, 7'd0, 8'd0}}
  };

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Advance the tracker by one pixel; return 1 with the beacon result on the last pixel
  function automatic bit track_pixel(input logic [lsbr_pkg::SMP_W-1:0] smp, input bit fe,
                                     output lsbr_pkg::result_t res);
    int             ctr;
    int             mid;
    int             cw;
    lsbr_pkg::dir_e dir;
    res = '0;
    if (smp > thr_q) begin
      if (run_len == 0) run_st = pix_idx;
      if (run_len < lsbr_pkg::PIXELS) run_len = run_len + 1'b1;
      if (run_len > best_w) begin
        best_st = run_st;
        best_w  = run_len;
      end
    end else begin
      run_len = '0;
    end
    if (pix_idx < lsbr_pkg::PIXELS - 1) pix_idx = pix_idx + 1'b1;
    if (!fe) return 1'b0;

    mid = lsbr_pkg::PIXELS / 2;
    cw  = int'(cw_q);
    if (best_w > minw_q) begin
      ctr = int'(best_st) + int'(best_w) / 2;
      if (ctr > lsbr_pkg::PIXELS - 1) ctr = lsbr_pkg::PIXELS - 1;
      // exact middle centers even with a zero window
      if ((ctr < mid + cw && ctr > mid - cw) || ctr == mid) dir = lsbr_pkg::DIR_CENTER;
      else if (ctr < mid) dir = lsbr_pkg::DIR_LEFT;
      else dir = lsbr_pkg::DIR_RIGHT;
    end else begin
      ctr = -1;
      dir = lsbr_pkg::DIR_NONE;
    end
    res.direction  = dir;
    res.center     = 8'(ctr);
    res.best_start = best_st;
    res.best_width = best_w;
    pix_idx = '0;
    run_len = '0;
    run_st  = '0;
    best_st = '0;
    best_w  = '0;
    return 1'b1;
  endfunction

  function automatic logic [lsbr_pkg::SMP_W-1:0] lit_value();
    if (thr_q == 10'd1023) return 10'd1023;
    if ($urandom_range(0, 3) == 0) return thr_q + 1'b1;
    return 10'($urandom_range(int'(thr_q) + 1, 1023));
  endfunction

  function automatic logic [lsbr_pkg::SMP_W-1:0] dark_value();
    if ($urandom_range(0, 3) == 0) return thr_q;
    return 10'($urandom_range(0, int'(thr_q)));
  endfunction

  task automatic send_pixel(input logic [lsbr_pkg::SMP_W-1:0] smp, input bit fe,
                            input bit typed, input lsbr_pkg::result_t want);
    int                gap;
    bit                has;
    lsbr_pkg::result_t pred;
    gap = src_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid     <= 1'b1;
    pix_if.sample    <= smp;
    pix_if.frame_end <= fe;
    do @(posedge clk_i); while (!pix_if.ready);
    has = track_pixel(smp, fe, pred);
    if (has) pending_beacons.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic send_line(input bit typed, input lsbr_pkg::result_t want);
    for (int i = 0; i < line_buf.size(); i++)
      send_pixel(line_buf[i], i == line_buf.size() - 1, typed, want);
  endtask

  // Drop valid and hold until every result is back and the core has drained
  task automatic settle_core();
    pix_if.valid <= 1'b0;
    while (pending_beacons.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input int thr, input int minw, input int cw);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= lsbr_pkg::CFG_THRESHOLD;
    cfg_data_i <= lsbr_pkg::CFG_DATA_W'(thr);
    @(posedge clk_i);
    cfg_idx_i  <= lsbr_pkg::CFG_MIN_WIDTH;
    cfg_data_i <= lsbr_pkg::CFG_DATA_W'(minw);
    @(posedge clk_i);
    cfg_idx_i  <= lsbr_pkg::CFG_CENTERED_WIDTH;
    cfg_data_i <= lsbr_pkg::CFG_DATA_W'(cw);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_q  = lsbr_pkg::THR_W'(thr);
    minw_q = lsbr_pkg::MINW_W'(minw);
    cw_q   = lsbr_pkg::CW_W'(cw);
  endtask

  task automatic build_row_line(input line_row_t row);
    int n;
    line_buf.delete();
    n = row.lead + row.run_a + row.gap + row.run_b + row.tail;
    for (int i = 0; i < n; i++) begin
      if ((i >= row.lead && i < row.lead + row.run_a) ||
          (i >= row.lead + row.run_a + row.gap && i < n - row.tail))
        line_buf.push_back(lsbr_pkg::SMP_W'(row.lit));
      else
        line_buf.push_back(lsbr_pkg::SMP_W'(row.dark));
    end
  endtask

  task automatic build_random_line();
    int len;
    int seg;
    int seg_max;
    int r;
    bit lit_on;
    line_buf.delete();
    r = $urandom_range(0, 99);
    if (short_lines) len = $urandom_range(1, 3);
    else if (r < 45) len = $urandom_range(1, 12);
    else if (r < 85) len = $urandom_range(13, 128);
    else len = $urandom_range(129, 170);
    if ($urandom_range(0, 6) == 0) begin
      // raw noise, every code possible
      repeat (len) line_buf.push_back(lsbr_pkg::SMP_W'($urandom_range(0, 1023)));
    end else begin
      seg_max = (len < 8) ? 2 : len / 3;
      lit_on  = $urandom_range(0, 1);
      while (line_buf.size() < len) begin
        seg = $urandom_range(1, seg_max);
        for (int k = 0; k < seg && line_buf.size() < len; k++)
          line_buf.push_back(lit_on ? lit_value() : dark_value());
        lit_on = !lit_on;
      end
    end
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1023;
      2: return 512;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  function automatic int pick_min_width();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 128;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic int pick_centered_width();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 64;
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  // Stimulus: directed lines from the table, then random phases
  initial begin
    int phase_items;
    int phase_lines;
    lsbr_pkg::result_t none_res;
    none_res = '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= lsbr_pkg::CFG_THRESHOLD;
    cfg_data_i       <= '0;
    pix_if.valid     <= 1'b0;
    pix_if.sample    <= '0;
    pix_if.frame_end <= 1'b0;
    rst_ni           <= 1'b0;
    thr_q   = lsbr_pkg::THRESHOLD_RST;
    minw_q  = lsbr_pkg::MIN_WIDTH_RST;
    cw_q    = lsbr_pkg::CENTERED_WIDTH_RST;
    pix_idx = '0;
    run_len = '0;
    run_st  = '0;
    best_st = '0;
    best_w  = '0;
    n_fail        = 0;
    items_sent    = 0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    long_hold_req = 1'b0;
    short_lines   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (line_table[i]) begin
      if (line_table[i].thr != thr_q || line_table[i].minw != minw_q ||
          line_table[i].cw != cw_q) begin
        settle_core();
        load_config(line_table[i].thr, line_table[i].minw, line_table[i].cw);
      end
      build_row_line(line_table[i]);
      send_line(line_table[i].typed, line_table[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_core();
      if (ph == 0) load_config(0, 0, 0);
      else if (ph == 1) load_config(1023, 128, 64);
      else load_config(pick_threshold(), pick_min_width(), pick_centered_width());
      src_calm    = ($urandom_range(0, 3) == 0);
      sink_calm   = ($urandom_range(0, 3) == 0);
      short_lines = 1'b0;
      if (ph == 2) begin
        // stall the result side while short lines of one to three pixels keep coming
        src_calm      = 1'b1;
        short_lines   = 1'b1;
        long_hold_req = 1'b1;
      end
      phase_items = items_sent;
      phase_lines = 0;
      while (items_sent - phase_items < PHASE_PIXELS || phase_lines < PHASE_LINES) begin
        build_random_line();
        send_line(1'b0, none_res);
        phase_lines++;
      end
    end

    settle_core();
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, one long hold on request, field-by-field compare
  initial begin : result_sink
    int                stall;
    lsbr_pkg::result_t want;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 6);
      if (long_hold_req) begin
        stall = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      if (pending_beacons.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("unexpected result: dir %0d center %0d start %0d width %0d",
                   res_if.direction, res_if.center, res_if.best_start, res_if.best_width);
      end else begin
        want = pending_beacons.pop_front();
        if (res_if.direction !== want.direction || res_if.center !== want.center ||
            res_if.best_start !== want.best_start || res_if.best_width !== want.best_width)
        begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("mismatch: dir %0d/%0d center %0d/%0d start %0d/%0d width %0d/%0d",
                     want.direction, res_if.direction, want.center, res_if.center,
                     want.best_start, res_if.best_start, want.best_width, res_if.best_width);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hdl/lsbr_pkg.sv
hdl/lsbr_ifs.sv
hdl/lsbr_tracker.sv
hdl/lsbr_out_buf.sv
hdl/line_scan_beacon_run_finder_core.sv
sim/tb_line_scan_beacon_run_finder_core.sv
